### rtl/core/hsa_pkg.sv
// shared types and constants for the handle slot allocator
package hsa_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam logic [12:0] BLOCK_SIZE_RST = 13'd64;
  localparam logic [31:0] NO_HANDLE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_COMPACT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_BAD_HANDLE = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_CMP,
    S_REPORT,
    S_COMPACT,
    S_MOVE,
    S_FINISH
  } state_t;

  typedef struct packed {
    stat_t       status;
    logic [31:0] handle_out;
    logic        handle_valid;
    logic [3:0]  slot_index;
    logic [15:0] byte_offset;
    logic [4:0]  occupied_count;
    logic [4:0]  slot_count;
  } res_t;

endpackage

### rtl/core/hsa_mem.sv
// slot id and user word memories, one write and one registered read port
module hsa_mem #(
  parameter int unsigned CAPACITY = hsa_pkg::CAPACITY_DEF,
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [31:0]   wr_id,
  input  logic [31:0]   wr_user,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [31:0]   rd_id,
  output logic [31:0]   rd_user
);
  import hsa_pkg::*;

  logic [31:0] id_mem [CAPACITY];
  logic [31:0] user_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]   <= wr_id;
      user_mem[wr_addr] <= wr_user;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id   <= id_mem[rd_addr];
      rd_user <= user_mem[rd_addr];
    end
  end

endmodule

### rtl/core/hsa_ctrl.sv
// sequencer: occupancy bits, counters, id search, allocate and compaction walk
module hsa_ctrl #(
  parameter int unsigned CAPACITY = hsa_pkg::CAPACITY_DEF,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsa_pkg::op_t        op_in,
  input  logic [31:0]         hid_in,
  input  logic [31:0]         user_in,
  input  logic [12:0]         block_size,
  output logic                res_valid,
  input  logic                res_ready,
  output hsa_pkg::res_t       res,
  output logic                wr_en,
  output logic [IW-1:0]       wr_addr,
  output logic [31:0]         wr_id,
  output logic [31:0]         wr_user,
  output logic                rd_en,
  output logic [IW-1:0]       rd_addr,
  input  logic [31:0]         rd_id,
  input  logic [31:0]         rd_user
);
  import hsa_pkg::*;

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t          state, state_next;
  op_t             op_r;
  logic [31:0]     hid_r;
  logic [31:0]     user_r;
  logic [CW-1:0]   used, live;
  logic [31:0]     idc;
  logic [CAPACITY-1:0] live_bits;
  logic [CW-1:0]   k, j;
  logic            found;
  logic [IW-1:0]   at;

  logic            accept;
  logic            hit;
  logic            free_any;
  logic [IW-1:0]   free_pick;
  logic            can_alloc;
  logic [IW-1:0]   pick;
  logic [31:0]     new_id;
  logic            done;
  logic [IW-1:0]   idx;
  logic [IW+12:0]  prod;
  logic [31:0]     prod32;
  logic            lk_in_range;

  assign accept = in_valid && in_ready;
  assign hit = live_bits[k[IW-1:0]] && (rd_id == hid_r);
  assign new_id = (idc + 32'd1 == NO_HANDLE) ? 32'd0 : idc + 32'd1;
  assign lk_in_range = hid_r < 32'(used);

  always_comb begin
    free_any = 1'b0;
    free_pick = '0;
    for (int n = CAPACITY - 1; n >= 0; n--) begin
      if ((CW'(n) < used) && !live_bits[n]) begin
        free_any = 1'b1;
        free_pick = IW'(n);
      end
    end
  end

  assign can_alloc = (live < CAP) && (free_any || (used < CAP));
  assign pick = free_any ? free_pick : used[IW-1:0];

  always_comb begin
    idx = '0;
    if (state == S_ALLOC && can_alloc) begin
      idx = pick;
    end else if (state == S_REPORT) begin
      if (found) begin
        idx = at;
      end else if (op_r == OP_LOOKUP && lk_in_range) begin
        idx = hid_r[IW-1:0];
      end
    end
  end

  assign prod = (IW + 13)'(idx) * (IW + 13)'(block_size);
  assign prod32 = 32'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    res_valid = 1'b0;
    wr_en = 1'b0;
    wr_addr = pick;
    wr_id = new_id;
    wr_user = user_r;
    rd_en = 1'b0;
    rd_addr = k[IW-1:0];
    done = 1'b0;
    res.status = STAT_OK;
    res.handle_out = NO_HANDLE;
    res.handle_valid = 1'b0;
    res.slot_index = 4'(idx);
    res.byte_offset = prod32[15:0];
    res.occupied_count = 5'(live);
    res.slot_count = 5'(used);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_in)
            OP_ALLOC: state_next = S_ALLOC;
            OP_COMPACT: state_next = (used == '0) ? S_FINISH : S_COMPACT;
            default: begin
              state_next = (hid_in == NO_HANDLE || used == '0) ? S_REPORT : S_SCAN;
            end
          endcase
        end
      end
      S_ALLOC: begin
        res_valid = 1'b1;
        if (can_alloc) begin
          res.handle_out = new_id;
          res.handle_valid = 1'b1;
          res.occupied_count = 5'(live + CW'(1));
          res.slot_count = 5'((!free_any) ? used + CW'(1) : used);
        end else begin
          res.status = STAT_FULL;
        end
        if (res_ready) begin
          wr_en = can_alloc;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (hit || (k + CW'(1) >= used)) begin
          state_next = S_REPORT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_REPORT: begin
        res_valid = 1'b1;
        res.handle_valid = found;
        if (op_r == OP_FREE) begin
          if (found) begin
            res.occupied_count = 5'(live - CW'(1));
          end else begin
            res.status = STAT_BAD_HANDLE;
          end
        end else if (!found && !lk_in_range) begin
          res.status = STAT_BAD_HANDLE;
        end
        if (res_ready) begin
          done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_COMPACT: begin
        rd_addr = j[IW-1:0];
        if (k >= j) begin
          state_next = S_FINISH;
        end else if (!live_bits[k[IW-1:0]] && live_bits[j[IW-1:0]]) begin
          rd_en = 1'b1;
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        wr_en = 1'b1;
        wr_addr = k[IW-1:0];
        wr_id = rd_id;
        wr_user = rd_user;
        state_next = S_COMPACT;
      end
      S_FINISH: begin
        res_valid = 1'b1;
        res.slot_count = 5'(live);
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      live <= '0;
      idc <= '0;
      live_bits <= '0;
    end else begin
      case (state)
        S_ALLOC: begin
          if (res_ready && can_alloc) begin
            live_bits[pick] <= 1'b1;
            live <= live + CW'(1);
            idc <= new_id;
            if (!free_any) begin
              used <= used + CW'(1);
            end
          end
        end
        S_REPORT: begin
          if (done && found && op_r == OP_FREE) begin
            live_bits[at] <= 1'b0;
            live <= live - CW'(1);
          end
        end
        S_MOVE: begin
          live_bits[k[IW-1:0]] <= 1'b1;
          live_bits[j[IW-1:0]] <= 1'b0;
        end
        S_FINISH: begin
          if (res_ready) begin
            used <= live;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_in;
      hid_r <= hid_in;
      user_r <= user_in;
      k <= '0;
      j <= used - CW'(1);
      found <= 1'b0;
      at <= '0;
    end else begin
      case (state)
        S_CMP: begin
          if (hit) begin
            found <= 1'b1;
            at <= k[IW-1:0];
          end else if (k + CW'(1) < used) begin
            k <= k + CW'(1);
          end
        end
        S_COMPACT: begin
          if (k < j) begin
            if (live_bits[k[IW-1:0]]) begin
              k <= k + CW'(1);
            end else if (!live_bits[j[IW-1:0]]) begin
              j <= j - CW'(1);
            end
          end
        end
        S_MOVE: k <= k + CW'(1);
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/handle_slot_allocator_unit.sv
// top level of the handle slot allocator
//
//  channel  | handshake            | beat
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | operation, handle_id, user_data
//  out      | out_valid / out_stall| status .. slot_count
//  config   | cfg_wr_en            | cfg_wr_data (block size)
//
// allocate reports from its own state; deallocate and lookup walk the slot id
// memory with a registered read and a compare step per slot searched; compact
// walks the slots and adds a move step per moved slot.
// rst is synchronous and clears the counters and occupancy bits; the slot
// memories hold no reset. a new beat is taken while the previous result waits
// in the output register; a stalled output holds the sequencer at its result.
module handle_slot_allocator_unit #(
  parameter int unsigned CAPACITY = hsa_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] handle_id,
  input  logic [31:0] user_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] handle_out,
  output logic        handle_valid,
  output logic [3:0]  slot_index,
  output logic [15:0] byte_offset,
  output logic [4:0]  occupied_count,
  output logic [4:0]  slot_count
);
  import hsa_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  logic [12:0]   block_size;
  logic          in_ready;
  logic          res_valid, res_ready;
  res_t          res, res_q;
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_id, wr_user, rd_id, rd_user;

  assign in_stall = !in_ready;
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RST;
    end else if (cfg_wr_en) begin
      block_size <= cfg_wr_data;
    end
  end

  hsa_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op_in(op_t'(operation)), .hid_in(handle_id), .user_in(user_data),
    .block_size(block_size),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_id(wr_id), .wr_user(wr_user),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_id(rd_id), .rd_user(rd_user)
  );

  hsa_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk(clk),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_id(wr_id), .wr_user(wr_user),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_id(rd_id), .rd_user(rd_user)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign status = res_q.status;
  assign handle_out = res_q.handle_out;
  assign handle_valid = res_q.handle_valid;
  assign slot_index = res_q.slot_index;
  assign byte_offset = res_q.byte_offset;
  assign occupied_count = res_q.occupied_count;
  assign slot_count = res_q.slot_count;

endmodule
